### rtl/core/rational_accumulator_alu_core_macros.svh
// Assertion macros for the rational accumulator ALU core.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef RATIONAL_ACCUMULATOR_ALU_CORE_MACROS_SVH
`define RATIONAL_ACCUMULATOR_ALU_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define RAC_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational accumulator check failed");

// Check that cons holds in the cycle after ante.
`define RAC_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational accumulator check failed");

`endif

### rtl/core/rac_pkg.sv
// Shared types for the rational accumulator ALU core.
// No dependencies; used by rac_mul, rac_div and the top level.
package rac_pkg;

    typedef enum logic [2:0] {
        CMD_LOAD     = 3'd0,
        CMD_ADD      = 3'd1,
        CMD_SUB      = 3'd2,
        CMD_MUL      = 3'd3,
        CMD_DIV      = 3'd4,
        CMD_SIMPLIFY = 3'd5,
        CMD_COMPARE  = 3'd6
    } cmd_t;

    // Request to a serial arithmetic unit.
    typedef struct packed {
        logic start;
    } unit_req_t;

    // Status from a serial arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } unit_rsp_t;

endpackage

### rtl/core/rac_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, full product.
// Depends on rac_pkg for the unit request and status types.
module rac_mul #(
    parameter int WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rac_pkg::unit_req_t   req,
    input  logic [WIDTH-1:0]     a,
    input  logic [WIDTH-1:0]     b,
    output rac_pkg::unit_rsp_t   rsp,
    output logic [2*WIDTH-1:0]   product
);
    import rac_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [2*WIDTH-1:0] p_reg, p_next;
    logic [WIDTH-1:0]   a_reg, a_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [WIDTH:0]     sum;

    // Add the multiplicand into the upper half when the low bit is set
    assign sum = {1'b0, p_reg[2*WIDTH-1:WIDTH]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_comb
    begin
        p_next    = p_reg;
        a_next    = a_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            p_next    = {{WIDTH{1'b0}}, b};
            a_next    = a;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // Advance one bit and shift the partial product right
            p_next   = {sum, p_reg[WIDTH-1:1]};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg    <= '0;
            a_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            p_reg    <= p_next;
            a_reg    <= a_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign product  = p_reg;

endmodule

### rtl/core/rac_div.sv
// Restoring unsigned divider: one quotient bit per cycle.
// Depends on rac_pkg for the unit request and status types.
module rac_div #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rac_pkg::unit_req_t req,
    input  logic [WIDTH-1:0]   dividend,
    input  logic [WIDTH-1:0]   divisor,
    output rac_pkg::unit_rsp_t rsp,
    output logic [WIDTH-1:0]   quotient
);
    import rac_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             ge;

    // Bring down the next dividend bit and try the subtract
    assign shifted = {r_reg, q_reg[WIDTH-1]};
    assign ge      = shifted >= {1'b0, d_reg};
    assign diff    = shifted - {1'b0, d_reg};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            q_next   = {q_reg[WIDTH-2:0], ge};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            q_reg    <= q_next;
            r_reg    <= r_next;
            d_reg    <= d_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quotient = q_reg;

endmodule

### rtl/core/rational_accumulator_alu_core.sv
// Rational accumulator ALU: fraction accumulator with serial multiply, GCD and divide.
// Depends on rac_pkg, rac_mul, rac_div and rational_accumulator_alu_core_macros.svh.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | cmd, operand_num, operand_den
//  out     | out_valid / out_ready| result_num, result_den, is_equal/greater/less
//
// One beat at a time. Add, subtract, multiply and divide run three bit-serial
// products. Simplify runs the binary GCD loop plus two serial divides; compare
// does two reductions and two products. Reset sets the accumulator to 1/1.
// A stalled output holds the result register and the block finishes the next
// beat only once that register is free.
module rational_accumulator_alu_core #(
    parameter int WORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] operand_num,
    input  logic signed [31:0] operand_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_num,
    output logic signed [31:0] result_den,
    output logic               is_equal,
    output logic               is_greater,
    output logic               is_less
);
    import rac_pkg::*;

    localparam int W  = WORD_WIDTH;
    localparam int KW = $clog2(W + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_MUL_GO,
        S_MUL_WAIT,
        S_RED_START,
        S_GCD,
        S_GSHIFT,
        S_DIVN_WAIT,
        S_DIVD_WAIT,
        S_CMP_EQ,
        S_DONE
    } state_t;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        mag = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    state_t           state_reg, state_next;
    logic [2:0]       cmd_reg, cmd_next;
    logic [W-1:0]     acc_num_reg, acc_num_next;
    logic [W-1:0]     acc_den_reg, acc_den_next;
    logic [W-1:0]     op_num_reg, op_num_next;
    logic [W-1:0]     op_den_reg, op_den_next;
    logic             pass_reg, pass_next;
    logic [1:0]       idx_reg, idx_next;
    logic [2*W-1:0]   m0_reg, m0_next;
    logic [2*W-1:0]   m1_reg, m1_next;
    logic [W-1:0]     u_reg, u_next;
    logic [W-1:0]     v_reg, v_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [W-1:0]     qn_reg, qn_next;
    logic             eq_reg, eq_next;
    logic             gt_reg, gt_next;
    logic             lt_reg, lt_next;
    logic             out_valid_reg, out_valid_next;
    logic [31:0]      res_num_reg, res_num_next;
    logic [31:0]      res_den_reg, res_den_next;
    logic             res_eq_reg, res_eq_next;
    logic             res_gt_reg, res_gt_next;
    logic             res_lt_reg, res_lt_next;

    unit_req_t        mul_req, div_req;
    unit_rsp_t        mul_rsp, div_rsp;
    logic [W-1:0]     mul_a, mul_b;
    logic [2*W-1:0]   mul_p;
    logic [W-1:0]     div_n, div_q;

    logic [W-1:0]     red_num, red_den;
    logic [W-1:0]     qn_signed, qd_signed;
    state_t           post_red_state;
    logic             n1, n2;

    assign in_ready = (state_reg == S_IDLE);

    // Pick the pair under reduction: accumulator first, then the operand copy
    assign red_num = pass_reg ? op_num_reg : acc_num_reg;
    assign red_den = pass_reg ? op_den_reg : acc_den_reg;

    // Select product operands: raw patterns for arithmetic, magnitudes for compare
    always_comb
    begin
        mul_a = acc_den_reg;
        mul_b = op_num_reg;
        if (cmd_reg == CMD_COMPARE)
        begin
            mul_a = (idx_reg == 2'd0) ? mag(acc_num_reg) : mag(acc_den_reg);
            mul_b = (idx_reg == 2'd0) ? mag(op_den_reg) : mag(op_num_reg);
        end
        else
        begin
            case (idx_reg)
                2'd0:
                begin
                    mul_a = acc_num_reg;
                    mul_b = (cmd_reg == CMD_MUL) ? op_num_reg : op_den_reg;
                end
                2'd1:
                begin
                    mul_a = acc_den_reg;
                    mul_b = op_num_reg;
                end
                default:
                begin
                    mul_a = acc_den_reg;
                    mul_b = (cmd_reg == CMD_DIV) ? op_num_reg : op_den_reg;
                end
            endcase
        end
    end

    assign mul_req.start = (state_reg == S_MUL_GO);
    assign div_req.start = ((state_reg == S_GSHIFT) && (k_reg == '0) && (u_reg != '0))
                         || ((state_reg == S_DIVN_WAIT) && div_rsp.done);
    assign div_n         = (state_reg == S_GSHIFT) ? mag(red_num) : mag(red_den);

    // Restore signs of the reduced parts
    assign qn_signed = red_num[W-1] ? (~qn_reg + W'(1)) : qn_reg;
    assign qd_signed = red_den[W-1] ? (~div_q + W'(1)) : div_q;

    // Where to go once a reduction is finished
    always_comb
    begin
        if (cmd_reg == CMD_SIMPLIFY)
            post_red_state = S_DONE;
        else if (!pass_reg)
            post_red_state = S_RED_START;
        else
            post_red_state = S_CMP_EQ;
    end

    // Product signs for the exact compare
    assign n1 = (m0_reg != '0) && (acc_num_reg[W-1] ^ op_den_reg[W-1]);
    assign n2 = (mul_p != '0) && (acc_den_reg[W-1] ^ op_num_reg[W-1]);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        op_num_next    = op_num_reg;
        op_den_next    = op_den_reg;
        pass_next      = pass_reg;
        idx_next       = idx_reg;
        m0_next        = m0_reg;
        m1_next        = m1_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        qn_next        = qn_reg;
        eq_next        = eq_reg;
        gt_next        = gt_reg;
        lt_next        = lt_reg;
        out_valid_next = out_valid_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_eq_next    = res_eq_reg;
        res_gt_next    = res_gt_reg;
        res_lt_next    = res_lt_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next    = cmd;
                    op_num_next = W'(operand_num);
                    op_den_next = W'(operand_den);
                    eq_next     = 1'b0;
                    gt_next     = 1'b0;
                    lt_next     = 1'b0;
                    pass_next   = 1'b0;
                    idx_next    = 2'd0;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg) inside
                    CMD_LOAD:
                    begin
                        acc_num_next = op_num_reg;
                        if (op_den_reg != '0)
                            acc_den_next = op_den_reg;
                        state_next = S_DONE;
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                        state_next = S_MUL_GO;
                    CMD_SIMPLIFY, CMD_COMPARE:
                        state_next = S_RED_START;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_MUL_GO:
                state_next = S_MUL_WAIT;
            S_MUL_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (cmd_reg == CMD_COMPARE && idx_reg == 2'd1)
                    begin
                        // Signed order of the two exact products
                        if (n1 != n2)
                        begin
                            gt_next = n2;
                            lt_next = n1;
                        end
                        else
                        begin
                            gt_next = n1 ? (m0_reg < mul_p) : (m0_reg > mul_p);
                            lt_next = n1 ? (m0_reg > mul_p) : (m0_reg < mul_p);
                        end
                        state_next = S_DONE;
                    end
                    else if (idx_reg == 2'd2)
                    begin
                        // Combine the wrapped cross products
                        if (cmd_reg == CMD_ADD)
                            acc_num_next = m0_reg[W-1:0] + m1_reg[W-1:0];
                        else if (cmd_reg == CMD_SUB)
                            acc_num_next = m0_reg[W-1:0] - m1_reg[W-1:0];
                        else
                            acc_num_next = m0_reg[W-1:0];
                        if (mul_p[W-1:0] != '0)
                            acc_den_next = mul_p[W-1:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        if (idx_reg == 2'd0)
                            m0_next = mul_p;
                        else
                            m1_next = mul_p;
                        idx_next   = idx_reg + 2'd1;
                        state_next = S_MUL_GO;
                    end
                end
            end
            S_RED_START:
            begin
                u_next     = mag(red_num);
                v_next     = mag(red_den);
                k_next     = '0;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                // Binary GCD, one step per cycle; u ends up holding the odd part
                if (u_reg == '0)
                begin
                    u_next     = v_reg;
                    state_next = S_GSHIFT;
                end
                else if (v_reg == '0)
                    state_next = S_GSHIFT;
                else if (!u_reg[0] && !v_reg[0])
                begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!u_reg[0])
                    u_next = u_reg >> 1;
                else if (!v_reg[0])
                    v_next = v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_next = u_reg - v_reg;
                else
                    v_next = v_reg - u_reg;
            end
            S_GSHIFT:
            begin
                // Restore the common power of two, one bit per cycle
                if (k_reg != '0)
                begin
                    u_next = u_reg << 1;
                    k_next = k_reg - KW'(1);
                end
                else if (u_reg == '0)
                begin
                    if (pass_reg == 1'b0 && cmd_reg == CMD_COMPARE)
                        pass_next = 1'b1;
                    state_next = post_red_state;
                end
                else
                    state_next = S_DIVN_WAIT;
            end
            S_DIVN_WAIT:
            begin
                if (div_rsp.done)
                begin
                    qn_next    = div_q;
                    state_next = S_DIVD_WAIT;
                end
            end
            S_DIVD_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (pass_reg)
                    begin
                        op_num_next = qn_signed;
                        if (qd_signed != '0)
                            op_den_next = qd_signed;
                    end
                    else
                    begin
                        acc_num_next = qn_signed;
                        if (qd_signed != '0)
                            acc_den_next = qd_signed;
                    end
                    if (pass_reg == 1'b0 && cmd_reg == CMD_COMPARE)
                        pass_next = 1'b1;
                    state_next = post_red_state;
                end
            end
            S_CMP_EQ:
            begin
                eq_next    = (acc_num_reg == op_num_reg) && (acc_den_reg == op_den_reg);
                idx_next   = 2'd0;
                state_next = S_MUL_GO;
            end
            S_DONE:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    res_num_next   = 32'(signed'(acc_num_reg));
                    res_den_next   = 32'(signed'(acc_den_reg));
                    res_eq_next    = eq_reg;
                    res_gt_next    = gt_reg;
                    res_lt_next    = lt_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            acc_num_reg   <= W'(1);
            acc_den_reg   <= W'(1);
            op_num_reg    <= '0;
            op_den_reg    <= '0;
            pass_reg      <= 1'b0;
            idx_reg       <= '0;
            m0_reg        <= '0;
            m1_reg        <= '0;
            u_reg         <= '0;
            v_reg         <= '0;
            k_reg         <= '0;
            qn_reg        <= '0;
            eq_reg        <= 1'b0;
            gt_reg        <= 1'b0;
            lt_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            res_num_reg   <= '0;
            res_den_reg   <= '0;
            res_eq_reg    <= 1'b0;
            res_gt_reg    <= 1'b0;
            res_lt_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
            op_num_reg    <= op_num_next;
            op_den_reg    <= op_den_next;
            pass_reg      <= pass_next;
            idx_reg       <= idx_next;
            m0_reg        <= m0_next;
            m1_reg        <= m1_next;
            u_reg         <= u_next;
            v_reg         <= v_next;
            k_reg         <= k_next;
            qn_reg        <= qn_next;
            eq_reg        <= eq_next;
            gt_reg        <= gt_next;
            lt_reg        <= lt_next;
            out_valid_reg <= out_valid_next;
            res_num_reg   <= res_num_next;
            res_den_reg   <= res_den_next;
            res_eq_reg    <= res_eq_next;
            res_gt_reg    <= res_gt_next;
            res_lt_reg    <= res_lt_next;
        end
    end

    rac_mul #(
        .WIDTH (W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .a       (mul_a),
        .b       (mul_b),
        .rsp     (mul_rsp),
        .product (mul_p)
    );

    rac_div #(
        .WIDTH (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_n),
        .divisor  (u_reg),
        .rsp      (div_rsp),
        .quotient (div_q)
    );

    assign out_valid  = out_valid_reg;
    assign result_num = res_num_reg;
    assign result_den = res_den_reg;
    assign is_equal   = res_eq_reg;
    assign is_greater = res_gt_reg;
    assign is_less    = res_lt_reg;

`include "rational_accumulator_alu_core_macros.svh"

    `RAC_CHECK(a_den_nonzero, 1'b1, acc_den_reg != '0)
    `RAC_CHECK(a_mul_done_waited, mul_rsp.done, state_reg == S_MUL_WAIT)
    `RAC_CHECK(a_div_done_waited, div_rsp.done,
        (state_reg == S_DIVN_WAIT) || (state_reg == S_DIVD_WAIT))
    `RAC_CHECK_NEXT(a_one_beat, in_valid && in_ready, !in_ready)

endmodule
